### rtl/core/skdh_pkg.sv
// shared constants and hash mix functions for the string key double hash table
package skdh_pkg;
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	localparam logic [31:0] ROT_TOP  = 32'hf8000000;
	localparam logic [31:0] ROT_LOW  = 32'h07ffffff;
	localparam logic [31:0] ELF_LOW  = 32'h0fffffff;
	localparam logic [31:0] ELF_TOP  = 32'hf0000000;
	localparam int ROT_SHIFT = 27;
	localparam int ELF_SHIFT = 24;

	function automatic logic [31:0] rot_mix(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] top;
		logic [31:0] r;
		top = h & ROT_TOP;
		r = (h & ROT_LOW) << 5;
		r = r ^ (top >> ROT_SHIFT);
		return r ^ {24'd0, c};
	endfunction

	function automatic logic [31:0] elf_mix(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] top;
		logic [31:0] r;
		r = (h & ELF_LOW) << 4;
		r = r + {24'd0, c};
		top = r & ELF_TOP;
		r = r ^ (top >> ELF_SHIFT);
		return r ^ top;
	endfunction
endpackage

### rtl/core/string_key_double_hash_table_core.sv
// top level: name collection, double hashed probe and insert over a name memory
// after the last byte: a setup state, then for each used slot probed a read and
//   compare of its name bytes, or a write of the new name into a free slot, then the result
// throughput: one name byte per cycle while a name arrives and in_stall is low; the probe
//   loop over the single name memory port sets the lookup time
// reset: used bits, type count, name length and hashes clear at once; no sweep
module string_key_double_hash_table_core
	import skdh_pkg::*;
#(
	parameter int TABLE_SLOTS = 256,
	parameter int NAME_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] name_char,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] slot_index,
	output logic [7:0] type_number,
	output logic [1:0] status
);
	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int BW = $clog2(NAME_BYTES);
	localparam int LW = $clog2(NAME_BYTES + 1);
	// a memory row spans a power of two columns
	localparam int ROW = 1 << BW;

	typedef enum logic [2:0] {
		S_COLLECT, S_START, S_READ, S_CMP, S_WRITE, S_DONE
	} state_t;

	state_t state_q;

	// name memory: one row per slot, one byte per column
	logic [7:0] name_mem [TABLE_SLOTS * ROW];
	logic [7:0] num_mem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] used_q;
	// key bytes of the name being collected
	logic [7:0] key_q [NAME_BYTES];

	logic [LW-1:0] len_q;
	logic [31:0] ph_q, sh_q;
	logic [7:0] count_q;
	logic [SW-1:0] offs_q, step_q;
	logic [SW:0] probes_q;
	logic [BW-1:0] col_q;
	logic [LW-1:0] wcol_q;
	logic match_q;
	logic [7:0] rd_byte_s1;
	logic [7:0] rd_num_s1;

	// memory port control
	logic mem_wr;
	logic [SW+BW-1:0] mem_addr;
	logic [7:0] mem_wdata;
	logic [BW-1:0] col_prev;
	logic [7:0] key_at_prev;
	logic [7:0] key_at_wcol;

	assign in_stall = (state_q != S_COLLECT) || (out_valid && out_stall);
	wire in_acc = in_valid && !in_stall;

	// key byte for the column read in the previous cycle, and for the write column; zero past the name length
	assign col_prev = col_q - BW'(1);
	assign key_at_prev = ({{(32-LW){1'b0}}, len_q} > 32'(col_prev)) ? key_q[col_prev] : 8'd0;
	assign key_at_wcol = ({{(32-LW){1'b0}}, len_q} > 32'(wcol_q[BW-1:0])) ?
		key_q[wcol_q[BW-1:0]] : 8'd0;

	always_comb begin
		mem_wr = (state_q == S_WRITE);
		mem_addr = mem_wr ? {offs_q, wcol_q[BW-1:0]} : {offs_q, col_q};
		mem_wdata = key_at_wcol;
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			name_mem[mem_addr] <= mem_wdata;
		end
		rd_byte_s1 <= name_mem[mem_addr];
		rd_num_s1 <= num_mem[offs_q];
		if (state_q == S_WRITE && wcol_q == LW'(0)) begin
			num_mem[offs_q] <= count_q;
		end
	end

	// key buffer, written as bytes arrive
	always_ff @(posedge clk) begin
		if (in_acc && name_char != 8'd0 && len_q < LW'(NAME_BYTES)) begin
			key_q[len_q[BW-1:0]] <= name_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			used_q <= '0;
			count_q <= '0;
			len_q <= '0;
			ph_q <= '0;
			sh_q <= '0;
			out_valid <= 1'b0;
			slot_index <= '0;
			type_number <= '0;
			status <= ST_FOUND;
			offs_q <= '0;
			step_q <= '0;
			probes_q <= '0;
			col_q <= '0;
			wcol_q <= '0;
			match_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						if (name_char != 8'd0) begin
							ph_q <= rot_mix(ph_q, name_char);
							sh_q <= elf_mix(sh_q, name_char);
							if (len_q < LW'(NAME_BYTES)) begin
								len_q <= len_q + LW'(1);
							end
						end
						if (last_char) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					// final mix with a zero byte, step forced odd
					offs_q <= SW'(rot_mix(ph_q, 8'd0));
					step_q <= SW'(elf_mix(sh_q, 8'd0) | 32'd1);
					probes_q <= '0;
					if (len_q > LW'(NAME_BYTES - 1)) begin
						slot_index <= '0;
						type_number <= '0;
						status <= ST_LONG;
						state_q <= S_DONE;
					end else begin
						col_q <= '0;
						match_q <= 1'b1;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// first byte of this slot is being read
					if (probes_q == (SW+1)'(TABLE_SLOTS)) begin
						slot_index <= '0;
						type_number <= '0;
						status <= ST_FULL;
						state_q <= S_DONE;
					end else if (!used_q[offs_q]) begin
						wcol_q <= '0;
						state_q <= S_WRITE;
					end else begin
						col_q <= col_q + BW'(1);
						match_q <= 1'b1;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					// rd_byte_s1 holds byte col_q-1
					if (rd_byte_s1 != key_at_prev) begin
						match_q <= 1'b0;
					end
					if (col_q == BW'(NAME_BYTES)) begin
						// all bytes read; this is the last compare
						if (match_q && rd_byte_s1 == key_at_prev) begin
							slot_index <= 8'(offs_q);
							type_number <= rd_num_s1;
							status <= ST_FOUND;
							state_q <= S_DONE;
						end else begin
							offs_q <= offs_q + step_q;
							probes_q <= probes_q + (SW+1)'(1);
							col_q <= '0;
							state_q <= S_READ;
						end
					end else begin
						col_q <= col_q + BW'(1);
					end
				end
				S_WRITE: begin
					if (wcol_q == LW'(NAME_BYTES - 1)) begin
						used_q[offs_q] <= 1'b1;
						count_q <= count_q + 8'd1;
						slot_index <= 8'(offs_q);
						type_number <= count_q;
						status <= ST_ADDED;
						state_q <= S_DONE;
					end else begin
						wcol_q <= wcol_q + LW'(1);
					end
				end
				S_DONE: begin
					// the previous result has always left by now
					if (!out_valid) begin
						out_valid <= 1'b1;
						len_q <= '0;
						ph_q <= '0;
						sh_q <= '0;
						state_q <= S_COLLECT;
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end
endmodule

### rtl/core/skdh_checker.sv
// port checker for the string key double hash table, with its bind
module skdh_checker
	import skdh_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       last_char,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] slot_index,
	input logic [7:0] type_number,
	input logic [1:0] status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index))
		else $error("stalled result changed");
	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_LONG || status == ST_FULL) |->
		slot_index == 8'd0 && type_number == 8'd0)
		else $error("long or full result carries a slot");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_char |=> !out_valid || $past(out_valid))
		else $error("result too early");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_char |=> in_stall)
		else $error("request taken during lookup");
endmodule

bind string_key_double_hash_table_core skdh_checker u_skdh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.last_char(last_char), .out_valid(out_valid), .out_stall(out_stall),
	.slot_index(slot_index), .type_number(type_number), .status(status)
);
